@@ src/htfd_pkg.sv @@
// ----------------------------------------------------------------------------
// htfd_pkg
// Types, constants and the CRC-8 step shared by the frame decoder modules.
// ----------------------------------------------------------------------------
package htfd_pkg;

  localparam int ByteW      = 8;
  localparam int RawW       = 20;
  localparam int HumCentiW  = 14;
  localparam int TempCentiW = 15;
  localparam int PosW       = 3;
  localparam int OutDataW   = 72;
  localparam int QueueDepth = 2;
  localparam int QueuePtrW  = $clog2(QueueDepth);
  localparam int QueueCntW  = $clog2(QueueDepth + 1);

  localparam logic [ByteW-1:0] CrcInit   = 8'hFF;
  localparam logic [ByteW-1:0] CrcPoly   = 8'h31;
  localparam logic [PosW-1:0]  LastPos   = 3'd6;

  localparam logic [13:0] HumScale  = 14'd10000;
  localparam logic [14:0] TempScale = 15'd20000;
  localparam logic [15:0] TempOffset = 16'd5000;

  localparam int HumProdW  = RawW + 14;
  localparam int TempProdW = RawW + 15;

  typedef enum logic [1:0] {
    STATUS_OK   = 2'd0,
    STATUS_BUSY = 2'd1,
    STATUS_CRC  = 2'd2
  } status_code_t;

  typedef struct packed {
    status_code_t     status;
    logic [RawW-1:0]  hum_raw;
    logic [RawW-1:0]  temp_raw;
  } frame_t;

  // MSB-first CRC-8 fold of one byte.
  function automatic logic [ByteW-1:0] crc8_fold(input logic [ByteW-1:0] crc,
                                                 input logic [ByteW-1:0] b);
    logic [ByteW-1:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

@@ src/htfd_front.sv @@
// ----------------------------------------------------------------------------
// htfd_front
// Byte assembler: tracks frame position, folds the CRC, builds the raw fields.
// ----------------------------------------------------------------------------
module htfd_front
  import htfd_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic [ByteW-1:0] rx_byte,
  input  logic             frame_start,
  output logic             push,
  output frame_t           push_frame
);

  logic [ByteW-1:0] crc;
  logic [PosW-1:0]  pos;
  logic             busy;
  logic [RawW-1:0]  hum_acc;
  logic [RawW-1:0]  temp_acc;

  logic [ByteW-1:0] crc_cur;
  logic [PosW-1:0]  pos_cur;
  logic             busy_next;
  logic [RawW-1:0]  hum_next;
  logic [RawW-1:0]  temp_next;

  always_comb begin
    // restart on a frame marker or an impossible count
    if (frame_start || (pos > LastPos)) begin
      pos_cur = '0;
      crc_cur = CrcInit;
    end else begin
      pos_cur = pos;
      crc_cur = crc;
    end
    busy_next = busy;
    hum_next  = hum_acc;
    temp_next = temp_acc;
    case (pos_cur)
      3'd0: busy_next = rx_byte[7];
      3'd1: hum_next  = {rx_byte, 12'd0};
      3'd2: hum_next  = hum_acc | {8'd0, rx_byte, 4'd0};
      3'd3: begin
        hum_next  = hum_acc | {16'd0, rx_byte[7:4]};
        temp_next = {rx_byte[3:0], 16'd0};
      end
      3'd4: temp_next = temp_acc | {4'd0, rx_byte, 8'd0};
      3'd5: temp_next = temp_acc | {12'd0, rx_byte};
      default: ;
    endcase
  end

  assign push = accept && (pos_cur == LastPos);

  always_comb begin
    push_frame.hum_raw  = hum_acc;
    push_frame.temp_raw = temp_acc;
    if (busy) begin
      push_frame.status = STATUS_BUSY;
    end else if (crc_cur != rx_byte) begin
      push_frame.status = STATUS_CRC;
    end else begin
      push_frame.status = STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc      <= CrcInit;
      pos      <= '0;
      busy     <= 1'b0;
      hum_acc  <= '0;
      temp_acc <= '0;
    end else if (accept) begin
      busy     <= busy_next;
      hum_acc  <= hum_next;
      temp_acc <= temp_next;
      if (pos_cur == LastPos) begin
        pos <= '0;
        crc <= CrcInit;
      end else begin
        pos <= pos_cur + 3'd1;
        crc <= crc8_fold(crc_cur, rx_byte);
      end
    end
  end

endmodule

@@ src/htfd_queue.sv @@
// ----------------------------------------------------------------------------
// htfd_queue
// Small frame queue between the assembler and the conversion pipeline.
// ----------------------------------------------------------------------------
module htfd_queue
  import htfd_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  frame_t push_frame,
  input  logic   pop,
  output frame_t pop_frame,
  output logic   full,
  output logic   empty
);

  frame_t               mem [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr;
  logic [QueuePtrW-1:0] rd_ptr;
  logic [QueueCntW-1:0] count;

  assign full      = (count == QueueCntW'(QueueDepth));
  assign empty     = (count == '0);
  assign pop_frame = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_frame;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + QueueCntW'(1);
        2'b01:   count <= count - QueueCntW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

@@ src/htfd_back.sv @@
// ----------------------------------------------------------------------------
// htfd_back
// Conversion pipeline: constant multiplies, offset, and the output register.
// ----------------------------------------------------------------------------
module htfd_back
  import htfd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  frame_t                in_frame,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output frame_t                out_frame,
  output logic [HumCentiW-1:0]  out_hum_centi,
  output logic [TempCentiW-1:0] out_temp_centi
);

  logic                 s1_valid;
  frame_t               s1_frame;
  logic [HumProdW-1:0]  s1_hum_prod;
  logic [TempProdW-1:0] s1_temp_prod;

  logic                 s1_move;
  logic [15:0]          temp_diff;

  assign s1_move = s1_valid && (!out_valid || out_ready);
  assign pop     = in_valid && (!s1_valid || s1_move);

  // floor(raw*scale / 2^20), then take off the offset
  assign temp_diff = {1'b0, s1_temp_prod[TempProdW-1:RawW]} - TempOffset;

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_frame     <= in_frame;
      s1_hum_prod  <= HumProdW'(in_frame.hum_raw) * HumProdW'(HumScale);
      s1_temp_prod <= TempProdW'(in_frame.temp_raw) * TempProdW'(TempScale);
    end
    if (s1_move) begin
      out_frame      <= s1_frame;
      out_hum_centi  <= s1_hum_prod[HumProdW-1:RawW];
      out_temp_centi <= temp_diff[TempCentiW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ src/humidity_temp_frame_decoder.sv @@
// ----------------------------------------------------------------------------
// humidity_temp_frame_decoder
// Decodes the 7-byte humidity/temperature measurement frame into values.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one response byte per word in s_tdata, s_tuser high on the
//   first (status) byte of a frame. Bytes may arrive every cycle while s_tready is high.
//   Master stream: one word per completed frame (seventh byte), carrying the
//   status, both raw 20-bit fields and both values in hundredths.
// Path: a completed frame passes the queue, the product stage and the output register.
// Throughput: one byte per cycle while s_tready is high; the assembler folds the CRC
//   as each byte is taken, and the conversion pipeline takes a frame every cycle
//   unless m_tready holds it back.
// Stall: a two-entry queue sits between the assembler and the conversion
//   pipeline; s_tready drops only when the queue is full, which happens when
//   the receiver holds m_tready low long enough to back up the pipeline.
// Reset: rst clears the frame position, CRC (to 0xFF), queue and all valid
//   flags; no word is presented until a full frame has been received.
// ----------------------------------------------------------------------------
module humidity_temp_frame_decoder
  import htfd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [ByteW-1:0]    s_tdata,   // [7:0] rx_byte
  input  logic                s_tuser,   // [0] frame_start
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [OutDataW-1:0] m_tdata    // [1:0] status_code, [21:2] humidity_raw,
                                         // [41:22] temperature_raw,
                                         // [55:42] humidity_centi,
                                         // [70:56] temperature_centi, [71] zero
);

  logic                  accept;
  logic                  push;
  frame_t                push_frame;
  logic                  pop;
  frame_t                pop_frame;
  logic                  q_full;
  logic                  q_empty;
  frame_t                out_frame;
  logic [HumCentiW-1:0]  hum_centi;
  logic [TempCentiW-1:0] temp_centi;

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;

  htfd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .rx_byte     (s_tdata),
    .frame_start (s_tuser),
    .push        (push),
    .push_frame  (push_frame)
  );

  htfd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_frame (push_frame),
    .pop        (pop),
    .pop_frame  (pop_frame),
    .full       (q_full),
    .empty      (q_empty)
  );

  htfd_back u_back (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (!q_empty),
    .in_frame       (pop_frame),
    .pop            (pop),
    .out_valid      (m_tvalid),
    .out_ready      (m_tready),
    .out_frame      (out_frame),
    .out_hum_centi  (hum_centi),
    .out_temp_centi (temp_centi)
  );

  assign m_tdata = {1'b0, temp_centi, hum_centi, out_frame.temp_raw, out_frame.hum_raw,
                    out_frame.status};

endmodule
